// ----- src/ugps_pkg.sv -----
`default_nettype none

package ugps_pkg;

    // Stream payload widths, padded up to whole bytes
    localparam int S_TDATA_W   = 152;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 28;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WATCH   = 3'd1,
        PH_HIGH    = 3'd2,
        PH_LOW     = 3'd3,
        PH_RESTORE = 3'd4,
        PH_PAUSE   = 3'd5
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE_ENABLE     = 3'd0,
        CFG_HIGH_FREQ       = 3'd1,
        CFG_LOW_FREQ        = 3'd2,
        CFG_DWELL_SECONDS   = 3'd3,
        CFG_CYCLE_LIMIT     = 3'd4,
        CFG_ACTIVATION_SECS = 3'd5,
        CFG_TRIP_DELAY_SECS = 3'd6,
        CFG_UNDERLOAD_LIMIT = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        CONF_OK      = 2'd0,
        CONF_GIVE_UP = 2'd1,
        CONF_PENDING = 2'd2
    } confirm_t;

    localparam logic [1:0] RETRY_MAX = 2'd3;
    localparam logic [3:0] RETRY_GAP = 4'd5;
    localparam logic [7:0] CYCLE_SAT = 8'd255;

    typedef struct packed {
        logic        mode_enable;
        logic [15:0] high_freq;
        logic [15:0] low_freq;
        logic [15:0] dwell_seconds;
        logic [7:0]  cycle_limit;
        logic [15:0] activation_seconds;
        logic [15:0] trip_delay_seconds;
        logic [27:0] underload_limit;
    } cfg_t;

    // One registered control tick; underload is resolved on capture
    typedef struct packed {
        logic [31:0] now_seconds;
        logic        motor_running;
        logic        motor_stopped;
        logic [15:0] run_time_seconds;
        logic [15:0] actual_freq;
        logic        freq_reached;
        logic [15:0] setpoint_readback;
        logic        setpoint_valid;
        logic        underload;
    } item_t;

    typedef struct packed {
        logic        write_strobe;
        logic [15:0] write_value;
        logic [2:0]  mode_state;
        logic [7:0]  cycles_done;
        logic        high_reached_event;
        logic        low_reached_event;
    } result_t;

endpackage

`default_nettype wire

// ----- src/ugps_input_stage.sv -----
`default_nettype none

module ugps_input_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire ugps_pkg::item_t item_in,
    input  wire logic [15:0]     current_a,
    input  wire logic [15:0]     current_b,
    input  wire logic [15:0]     current_c,
    input  wire logic [12:0]     power_factor,
    input  wire logic [27:0]     underload_limit,
    input  wire logic            advance,
    output logic                 item_valid,
    output ugps_pkg::item_t      item_out
);

    logic            valid_reg;
    ugps_pkg::item_t item_reg;
    ugps_pkg::item_t item_next;
    logic [15:0]     imin_ab;
    logic [15:0]     imin;
    logic [28:0]     load_product;

    // Smallest phase current times cos phi, compared on capture
    always_comb begin
        imin_ab      = (current_a < current_b) ? current_a : current_b;
        imin         = (current_c < imin_ab) ? current_c : imin_ab;
        load_product = 29'(imin) * 29'(power_factor);
        item_next           = item_in;
        item_next.underload = (load_product < {1'b0, underload_limit});
    end

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ugps_ctrl.sv -----
`default_nettype none

module ugps_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire ugps_pkg::item_t item,
    input  wire ugps_pkg::cfg_t  cfg,
    output ugps_pkg::result_t    res
);

    ugps_pkg::phase_t   phase_reg, phase_next;
    logic [31:0]        trip_stamp_reg, trip_stamp_next;
    logic [31:0]        dwell_stamp_reg, dwell_stamp_next;
    logic [7:0]         cycle_count_reg, cycle_count_next;
    logic [15:0]        saved_setpoint_reg, saved_setpoint_next;
    logic [1:0]         retry_count_reg, retry_count_next;
    logic [3:0]         retry_wait_reg, retry_wait_next;

    logic [15:0]        target;
    ugps_pkg::confirm_t conf;
    logic [1:0]         conf_count;
    logic [3:0]         conf_wait;
    logic               conf_strobe;
    logic [31:0]        trip_elapsed;
    logic [31:0]        dwell_elapsed;
    logic [7:0]         cycle_inc;

    // Setpoint confirmation, shared by every purge phase
    always_comb begin
        case (phase_reg)
            ugps_pkg::PH_HIGH: target = cfg.high_freq;
            ugps_pkg::PH_LOW:  target = cfg.low_freq;
            default:           target = saved_setpoint_reg;
        endcase
        conf_strobe = 1'b0;
        conf_count  = retry_count_reg;
        conf_wait   = retry_wait_reg;
        if (item.setpoint_valid && item.setpoint_readback == target) begin
            conf       = ugps_pkg::CONF_OK;
            conf_count = 2'd0;
            conf_wait  = 4'd0;
        end else if (retry_wait_reg <= 4'd1) begin
            if (retry_count_reg >= ugps_pkg::RETRY_MAX) begin
                conf       = ugps_pkg::CONF_GIVE_UP;
                conf_count = 2'd0;
                conf_wait  = 4'd0;
            end else begin
                conf        = ugps_pkg::CONF_PENDING;
                conf_strobe = 1'b1;
                conf_wait   = ugps_pkg::RETRY_GAP;
                conf_count  = retry_count_reg + 2'd1;
            end
        end else begin
            conf      = ugps_pkg::CONF_PENDING;
            conf_wait = retry_wait_reg - 4'd1;
        end
    end

    always_comb begin
        trip_elapsed  = item.now_seconds - trip_stamp_reg;
        dwell_elapsed = item.now_seconds - dwell_stamp_reg;
        cycle_inc     = (cycle_count_reg < ugps_pkg::CYCLE_SAT) ?
                        cycle_count_reg + 8'd1 : cycle_count_reg;

        phase_next          = phase_reg;
        trip_stamp_next     = trip_stamp_reg;
        dwell_stamp_next    = dwell_stamp_reg;
        cycle_count_next    = cycle_count_reg;
        saved_setpoint_next = saved_setpoint_reg;
        retry_count_next    = retry_count_reg;
        retry_wait_next     = retry_wait_reg;
        res                 = '0;

        if ((!cfg.mode_enable || item.motor_stopped) && phase_reg != ugps_pkg::PH_IDLE) begin
            cycle_count_next = 8'd0;
            trip_stamp_next  = 32'd0;
            dwell_stamp_next = 32'd0;
            phase_next       = ugps_pkg::PH_IDLE;
        end else begin
            case (phase_reg)
                ugps_pkg::PH_IDLE: begin
                    if (cfg.mode_enable && item.motor_running &&
                        item.run_time_seconds >= cfg.activation_seconds) begin
                        trip_stamp_next = 32'd0;
                        phase_next      = ugps_pkg::PH_WATCH;
                    end
                end
                ugps_pkg::PH_WATCH: begin
                    if (item.underload) begin
                        if (trip_stamp_reg == 32'd0) begin
                            saved_setpoint_next = item.setpoint_readback;
                            trip_stamp_next     = item.now_seconds;
                        end else if (trip_elapsed >= {16'd0, cfg.trip_delay_seconds}) begin
                            phase_next = (cycle_count_reg >= cfg.cycle_limit) ?
                                         ugps_pkg::PH_PAUSE : ugps_pkg::PH_HIGH;
                        end
                    end else begin
                        cycle_count_next = 8'd0;
                        trip_stamp_next  = 32'd0;
                    end
                end
                ugps_pkg::PH_HIGH, ugps_pkg::PH_LOW: begin
                    retry_count_next = conf_count;
                    retry_wait_next  = conf_wait;
                    res.write_strobe = conf_strobe;
                    res.write_value  = conf_strobe ? target : 16'd0;
                    if (conf == ugps_pkg::CONF_OK) begin
                        if (item.freq_reached && item.actual_freq == target) begin
                            if (dwell_stamp_reg == 32'd0) begin
                                dwell_stamp_next = item.now_seconds;
                                if (phase_reg == ugps_pkg::PH_HIGH) begin
                                    res.high_reached_event = 1'b1;
                                end else begin
                                    res.low_reached_event = 1'b1;
                                end
                            end else if (dwell_elapsed >= {16'd0, cfg.dwell_seconds}) begin
                                phase_next = (phase_reg == ugps_pkg::PH_HIGH) ?
                                             ugps_pkg::PH_LOW : ugps_pkg::PH_RESTORE;
                            end
                        end else begin
                            dwell_stamp_next = 32'd0;
                        end
                    end else if (conf == ugps_pkg::CONF_GIVE_UP) begin
                        phase_next = (phase_reg == ugps_pkg::PH_HIGH) ?
                                     ugps_pkg::PH_LOW : ugps_pkg::PH_RESTORE;
                    end
                end
                ugps_pkg::PH_RESTORE: begin
                    retry_count_next = conf_count;
                    retry_wait_next  = conf_wait;
                    res.write_strobe = conf_strobe;
                    res.write_value  = conf_strobe ? target : 16'd0;
                    if ((conf == ugps_pkg::CONF_OK && item.freq_reached &&
                         item.actual_freq == saved_setpoint_reg) ||
                        conf == ugps_pkg::CONF_GIVE_UP) begin
                        trip_stamp_next  = 32'd0;
                        cycle_count_next = cycle_inc;
                        phase_next       = ugps_pkg::PH_WATCH;
                    end
                end
                ugps_pkg::PH_PAUSE: begin
                    phase_next = ugps_pkg::PH_PAUSE;
                end
                default: begin
                    phase_next = ugps_pkg::PH_IDLE;
                end
            endcase
        end

        res.mode_state  = phase_next;
        res.cycles_done = cycle_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= ugps_pkg::PH_IDLE;
            trip_stamp_reg     <= 32'd0;
            dwell_stamp_reg    <= 32'd0;
            cycle_count_reg    <= 8'd0;
            saved_setpoint_reg <= 16'd0;
            retry_count_reg    <= 2'd0;
            retry_wait_reg     <= 4'd0;
        end else if (step) begin
            phase_reg          <= phase_next;
            trip_stamp_reg     <= trip_stamp_next;
            dwell_stamp_reg    <= dwell_stamp_next;
            cycle_count_reg    <= cycle_count_next;
            saved_setpoint_reg <= saved_setpoint_next;
            retry_count_reg    <= retry_count_next;
            retry_wait_reg     <= retry_wait_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/underload_gas_purge_sequencer_core.sv -----
// Underload gas purge sequencer. Each control tick arrives as one transfer on
// the s_ stream and yields exactly one result transfer on the m_ stream. The
// block takes a tick every clock cycle: a tick is captured into an input
// register (where the smallest phase current times cos phi is compared with
// the underload limit), then state-machine logic updates the sequencer
// state and loads the output register. Throughput is one tick per cycle
// while the sink keeps m_tready high. The output register and the input
// register stall together on back-pressure.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// and must only change while no tick is in flight.
`default_nettype none

module underload_gas_purge_sequencer_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_we,
    input  wire logic [ugps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ugps_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata, from bit 0: now_seconds[31:0], motor_running[32],
    // motor_stopped[33], run_time_seconds[49:34], current_a[65:50],
    // current_b[81:66], current_c[97:82], power_factor[110:98],
    // actual_freq[126:111], freq_reached[127], setpoint_readback[143:128],
    // setpoint_valid[144], zero pad[151:145]
    input  wire logic [ugps_pkg::S_TDATA_W-1:0]       s_tdata,

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // m_tdata, from bit 0: write_strobe[0], write_value[16:1],
    // mode_state[19:17], cycles_done[27:20], high_reached_event[28],
    // low_reached_event[29], zero pad[31:30]
    output logic [ugps_pkg::M_TDATA_W-1:0]            m_tdata
);

    ugps_pkg::cfg_t    cfg_reg;
    ugps_pkg::item_t   item_in;
    ugps_pkg::item_t   item_cur;
    ugps_pkg::result_t res;
    logic              item_valid;
    logic              advance;
    logic              out_valid_reg;
    logic [ugps_pkg::M_TDATA_W-1:0] out_data_reg;

    // Configuration writes: no handshake, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (ugps_pkg::cfg_index_t'(cfg_index))
                ugps_pkg::CFG_MODE_ENABLE:     cfg_reg.mode_enable        <= cfg_wdata[0];
                ugps_pkg::CFG_HIGH_FREQ:       cfg_reg.high_freq          <= cfg_wdata[15:0];
                ugps_pkg::CFG_LOW_FREQ:        cfg_reg.low_freq           <= cfg_wdata[15:0];
                ugps_pkg::CFG_DWELL_SECONDS:   cfg_reg.dwell_seconds      <= cfg_wdata[15:0];
                ugps_pkg::CFG_CYCLE_LIMIT:     cfg_reg.cycle_limit        <= cfg_wdata[7:0];
                ugps_pkg::CFG_ACTIVATION_SECS: cfg_reg.activation_seconds <= cfg_wdata[15:0];
                ugps_pkg::CFG_TRIP_DELAY_SECS: cfg_reg.trip_delay_seconds <= cfg_wdata[15:0];
                ugps_pkg::CFG_UNDERLOAD_LIMIT: cfg_reg.underload_limit    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Unpack the tick; underload is filled in by the input stage
    always_comb begin
        item_in.now_seconds       = s_tdata[31:0];
        item_in.motor_running     = s_tdata[32];
        item_in.motor_stopped     = s_tdata[33];
        item_in.run_time_seconds  = s_tdata[49:34];
        item_in.actual_freq       = s_tdata[126:111];
        item_in.freq_reached      = s_tdata[127];
        item_in.setpoint_readback = s_tdata[143:128];
        item_in.setpoint_valid    = s_tdata[144];
        item_in.underload         = 1'b0;
    end

    // Advance the captured tick when the output register is free or drains
    assign advance = item_valid && (!out_valid_reg || m_tready);

    ugps_input_stage u_input (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .item_in         (item_in),
        .current_a       (s_tdata[65:50]),
        .current_b       (s_tdata[81:66]),
        .current_c       (s_tdata[97:82]),
        .power_factor    (s_tdata[110:98]),
        .underload_limit (cfg_reg.underload_limit),
        .advance         (advance),
        .item_valid      (item_valid),
        .item_out        (item_cur)
    );

    ugps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_cur),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Output register: hold the result until the sink takes the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, res.low_reached_event, res.high_reached_event,
                             res.cycles_done, res.mode_state, res.write_value,
                             res.write_strobe};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- src/ugps_checker.sv -----
`default_nettype none

module ugps_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ugps_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No setpoint value without a write request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("write_value set without write_strobe");

    // F1 reached only while in the high phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> m_tdata[19:17] == 3'(ugps_pkg::PH_HIGH))
        else $error("high event outside high phase");

    // F2 reached only while in the low phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> m_tdata[19:17] == 3'(ugps_pkg::PH_LOW))
        else $error("low event outside low phase");

    // Reset drops any pending result
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind underload_gas_purge_sequencer_core ugps_checker u_ugps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
